// File: rtl/core/touch_trimmed_mean_calibrate_defines.svh
// ---------------------------------------------------------------------------
// touch_trimmed_mean_calibrate_defines.svh
// Assertion macros shared by the touch calibration RTL.
// ---------------------------------------------------------------------------
`ifndef TOUCH_TRIMMED_MEAN_CALIBRATE_DEFINES_SVH
`define TOUCH_TRIMMED_MEAN_CALIBRATE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TTMC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define TTMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ttmc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ttmc_pkg
// Widths, register codes, reset values and transfer types for the touch
// trimmed-mean calibration pipeline.
// ---------------------------------------------------------------------------
package ttmc_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int MID_W     = 14;   // sum of the three middle samples
  localparam int COORD_W   = 9;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 8;
  localparam int FRAC_W    = 12;   // Q4.12 fraction bits
  localparam int PROD_W    = CFG_W + SAMPLE_W + 1;
  localparam int ACC_W     = PROD_W + 1;

  localparam int SCREEN_WIDTH_DEF  = 240;
  localparam int SCREEN_HEIGHT_DEF = 320;

  // floor(x / 3) as (x * 21846) >> 16, exact for x below 3 * 4096
  localparam int RECIP_W     = 15;
  localparam int THIRD_SHIFT = 16;
  localparam logic [RECIP_W-1:0] THIRD_RECIP = RECIP_W'(21846);

  localparam logic signed [CFG_W-1:0] GAIN_ONE = 16'sd4096;
  localparam logic signed [CFG_W-1:0] OFFSET_ZERO = 16'sd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_GAIN   = 8'd0,
    REG_Y_GAIN   = 8'd1,
    REG_X_OFFSET = 8'd2,
    REG_Y_OFFSET = 8'd3
  } cfg_reg_t;

  typedef enum logic {
    AXIS_X = 1'b0,
    AXIS_Y = 1'b1
  } axis_t;

  // Calibration register set
  typedef struct packed {
    logic signed [CFG_W-1:0] x_gain;
    logic signed [CFG_W-1:0] y_gain;
    logic signed [CFG_W-1:0] x_offset;
    logic signed [CFG_W-1:0] y_offset;
  } cal_cfg_t;

  // Trimmed mean handed from the trim stages to the calibration stages
  typedef struct packed {
    logic                axis;
    logic [SAMPLE_W-1:0] mean;
  } trim_xfer_t;

endpackage

// File: rtl/core/ttmc_trim.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ttmc_trim
// Two pipeline stages: drop min and max of five samples and sum the rest,
// then divide the middle sum by three with a reciprocal multiply.
// ---------------------------------------------------------------------------
`include "touch_trimmed_mean_calibrate_defines.svh"

module ttmc_trim
  import ttmc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  logic                up_axis,
  input  logic [SAMPLE_W-1:0] up_s0,
  input  logic [SAMPLE_W-1:0] up_s1,
  input  logic [SAMPLE_W-1:0] up_s2,
  input  logic [SAMPLE_W-1:0] up_s3,
  input  logic [SAMPLE_W-1:0] up_s4,
  output logic                dn_valid,
  input  logic                dn_ready,
  output trim_xfer_t          dn_data
);

  logic                     va_r;
  logic                     axa_r;
  logic [MID_W-1:0]         mid_r;
  logic                     vb_r;
  trim_xfer_t               tb_r;
  logic                     a_adv;
  logic                     b_ready;
  logic [SAMPLE_W-1:0]      lo01, lo23, lo03, lo_all;
  logic [SAMPLE_W-1:0]      hi01, hi23, hi03, hi_all;
  logic [MID_W:0]           sum_all;
  logic [MID_W-1:0]         mid_nxt;
  logic [MID_W+RECIP_W-1:0] third_prod;
  logic [SAMPLE_W-1:0]      mean_nxt;

  // Min and max trees over the five samples
  always_comb begin
    lo01   = (up_s1 < up_s0) ? up_s1 : up_s0;
    lo23   = (up_s3 < up_s2) ? up_s3 : up_s2;
    lo03   = (lo23 < lo01) ? lo23 : lo01;
    lo_all = (up_s4 < lo03) ? up_s4 : lo03;
    hi01   = (up_s1 > up_s0) ? up_s1 : up_s0;
    hi23   = (up_s3 > up_s2) ? up_s3 : up_s2;
    hi03   = (hi23 > hi01) ? hi23 : hi01;
    hi_all = (up_s4 > hi03) ? up_s4 : hi03;
    sum_all = (MID_W+1)'(up_s0) + (MID_W+1)'(up_s1) + (MID_W+1)'(up_s2)
            + (MID_W+1)'(up_s3) + (MID_W+1)'(up_s4);
    mid_nxt = MID_W'(sum_all - (MID_W+1)'(lo_all) - (MID_W+1)'(hi_all));
  end

  // Divide the middle sum by three
  assign third_prod = (MID_W+RECIP_W)'(mid_r) * (MID_W+RECIP_W)'(THIRD_RECIP);
  assign mean_nxt   = third_prod[THIRD_SHIFT +: SAMPLE_W];

  // Stall control: a stage moves when it is empty or its successor moves
  assign b_ready  = !vb_r || dn_ready;
  assign a_adv    = !va_r || b_ready;
  assign up_ready = a_adv;

  // Stage A: trimmed sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (a_adv) begin
      va_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && up_valid) begin
      axa_r <= up_axis;
      mid_r <= mid_nxt;
    end
  end

  // Stage B: mean
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (b_ready) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && va_r) begin
      tb_r.axis <= axa_r;
      tb_r.mean <= mean_nxt;
    end
  end

  assign dn_valid = vb_r;
  assign dn_data  = tb_r;

  // Checks
  `TTMC_ASSERT_NEXT(a_hold_chk, va_r && !b_ready, va_r, "trim stage A dropped a held item")
  `TTMC_ASSERT_SAME(mid_rng_chk, va_r, mid_r <= MID_W'(3 * ((1 << SAMPLE_W) - 1)), "middle sum out of range")

endmodule

// File: rtl/core/ttmc_calib.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ttmc_calib
// Two pipeline stages: multiply the mean by the axis gain, then add the
// offset, drop the fraction and clamp to the screen range.
// ---------------------------------------------------------------------------
`include "touch_trimmed_mean_calibrate_defines.svh"

module ttmc_calib
  import ttmc_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cal_cfg_t           cfg,
  input  logic               up_valid,
  output logic               up_ready,
  input  trim_xfer_t         up_data,
  output logic               dn_valid,
  input  logic               dn_stall,
  output logic               dn_axis,
  output logic [COORD_W-1:0] dn_coord
);

  localparam int Q_W = ACC_W - FRAC_W;
  localparam logic [Q_W-1:0] X_LIM = Q_W'(SCREEN_WIDTH - 1);
  localparam logic [Q_W-1:0] Y_LIM = Q_W'(SCREEN_HEIGHT - 1);
  localparam bit X_FITS = SCREEN_WIDTH <= (1 << COORD_W);
  localparam bit Y_FITS = SCREEN_HEIGHT <= (1 << COORD_W);
  localparam logic [COORD_W-1:0] X_TOP = COORD_W'(SCREEN_WIDTH - 1);
  localparam logic [COORD_W-1:0] Y_TOP = COORD_W'(SCREEN_HEIGHT - 1);

  logic                     vc_r;
  logic                     axc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [CFG_W-1:0]  off_r;
  logic                     vd_r;
  logic                     axd_r;
  logic [COORD_W-1:0]       coord_r;
  logic                     c_ready;
  logic                     d_ready;
  logic signed [CFG_W-1:0]  gain_sel;
  logic signed [CFG_W-1:0]  off_sel;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]  acc;
  logic [Q_W-1:0]           q;
  logic [Q_W-1:0]           lim;
  logic [Q_W-1:0]           clamped;
  logic [COORD_W-1:0]       coord_nxt;

  // Pick the axis constants and multiply
  always_comb begin
    gain_sel = (up_data.axis == AXIS_Y) ? cfg.y_gain : cfg.x_gain;
    off_sel  = (up_data.axis == AXIS_Y) ? cfg.y_offset : cfg.x_offset;
    prod_nxt = PROD_W'(gain_sel) * PROD_W'($signed({1'b0, up_data.mean}));
  end

  // Add offset, truncate the fraction, clamp
  always_comb begin
    acc = ACC_W'(prod_r) + (ACC_W'(off_r) <<< FRAC_W);
    q   = acc[ACC_W-1:FRAC_W];
    lim = (axc_r == AXIS_Y) ? Y_LIM : X_LIM;
    if (acc[ACC_W-1]) begin
      clamped = '0;
    end else if (q > lim) begin
      clamped = lim;
    end else begin
      clamped = q;
    end
    coord_nxt = clamped[COORD_W-1:0];
  end

  // Stall control
  assign d_ready  = !vd_r || !dn_stall;
  assign c_ready  = !vc_r || d_ready;
  assign up_ready = c_ready;

  // Stage C: product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (c_ready) begin
      vc_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && up_valid) begin
      axc_r  <= up_data.axis;
      prod_r <= prod_nxt;
      off_r  <= off_sel;
    end
  end

  // Stage D: output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (d_ready) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && vc_r) begin
      axd_r   <= axc_r;
      coord_r <= coord_nxt;
    end
  end

  assign dn_valid = vd_r;
  assign dn_axis  = axd_r;
  assign dn_coord = coord_r;

  // Checks
  `TTMC_ASSERT_SAME(x_clamp_chk, vd_r && (axd_r == AXIS_X), !X_FITS || (coord_r <= X_TOP), "X coordinate beyond screen")
  `TTMC_ASSERT_SAME(y_clamp_chk, vd_r && (axd_r == AXIS_Y), !Y_FITS || (coord_r <= Y_TOP), "Y coordinate beyond screen")

endmodule

// File: rtl/core/touch_trimmed_mean_calibrate.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// touch_trimmed_mean_calibrate
// Trimmed mean of five touch samples followed by per-axis linear
// calibration and clamping to the screen.
// ---------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | axis, five 12-bit samples
//   out_    | output    | out_valid / out_stall| axis_out, 9-bit coordinate
//   cfg_    | input     | cfg_valid / cfg_ready| 8-bit index, 16-bit data
//
// Four register stages (trim, divide by three, gain multiply, offset and
// clamp); one burst is taken per cycle while the stages are not held by a
// stall, and its result passes through all four registers before out_valid.
// cfg_ready is always high; writes to an index above
// three are ignored. Synchronous active-low reset empties the pipeline and
// loads unity gain and zero offset. A stall on out_ fills the stages and
// then reaches in_stall in the same cycle; nothing is dropped or repeated.
// ---------------------------------------------------------------------------

module touch_trimmed_mean_calibrate
  import ttmc_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_axis,
  input  logic [SAMPLE_W-1:0]  in_sample_first,
  input  logic [SAMPLE_W-1:0]  in_sample_second,
  input  logic [SAMPLE_W-1:0]  in_sample_third,
  input  logic [SAMPLE_W-1:0]  in_sample_fourth,
  input  logic [SAMPLE_W-1:0]  in_sample_fifth,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_axis_out,
  output logic [COORD_W-1:0]   out_coordinate,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cal_cfg_t   cfg_r;
  logic       trim_ready;
  logic       mid_valid;
  logic       mid_ready;
  trim_xfer_t mid_data;

  assign cfg_ready = 1'b1;

  // Calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_gain   <= GAIN_ONE;
      cfg_r.y_gain   <= GAIN_ONE;
      cfg_r.x_offset <= OFFSET_ZERO;
      cfg_r.y_offset <= OFFSET_ZERO;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_GAIN:   cfg_r.x_gain   <= cfg_wdata;
        REG_Y_GAIN:   cfg_r.y_gain   <= cfg_wdata;
        REG_X_OFFSET: cfg_r.x_offset <= cfg_wdata;
        REG_Y_OFFSET: cfg_r.y_offset <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = !trim_ready;

  ttmc_trim u_trim (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (trim_ready),
    .up_axis  (in_axis),
    .up_s0    (in_sample_first),
    .up_s1    (in_sample_second),
    .up_s2    (in_sample_third),
    .up_s3    (in_sample_fourth),
    .up_s4    (in_sample_fifth),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_data  (mid_data)
  );

  ttmc_calib #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_calib (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .up_data  (mid_data),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_axis  (out_axis_out),
    .dn_coord (out_coordinate)
  );

endmodule
